>>> sv/nco_real_to_complex_mixer_macros.svh
// Assertion macros shared by the NCO mixer RTL.
// Used by the files that check their own pipeline control; no other dependencies.
`ifndef NCO_REAL_TO_COMPLEX_MIXER_MACROS_SVH
`define NCO_REAL_TO_COMPLEX_MIXER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NCOMIX_ASSERT_NOW(label, clk_i, rst_ni, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error("ncomix assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define NCOMIX_ASSERT_NEXT(label, clk_i, rst_ni, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error("ncomix assertion failed");

`endif

>>> sv/ncomix_pkg.sv
// Package of the NCO real-to-complex mixer: constants, shared types and the
// elaboration-time sine table generator. No dependencies.
package ncomix_pkg;

	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_ADDR_BITS = 1;
	localparam int COEF_BITS = 16;
	localparam int COEF_FRAC = 15;

	localparam int DEF_SAMPLE_BITS = 16;
	localparam int DEF_PHASE_BITS = 32;
	localparam int DEF_TABLE_ADDR_BITS = 10;

	typedef enum logic [CFG_ADDR_BITS-1:0] {
		CFG_PHASE_STEP  = 1'b0,
		CFG_START_PHASE = 1'b1
	} cfg_reg_t;

	// Load enables of the two stages behind the table read.
	typedef struct packed {
		logic s2;
		logic out;
	} pipe_en_t;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned TAYLOR_DIV [8] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
	};

	// First-quadrant sine in Q30 by Taylor series, scaled to 32767 and clamped.
	// r runs from 0 to a quarter of the table; ab is the table address width.
	function automatic logic [COEF_BITS-1:0] quarter_sine(input int unsigned r,
		input int unsigned ab);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned sum;
		longint unsigned v;
		x = (HALF_PI_Q30 * longint'(r) + (64'd1 << (ab - 3))) >> (ab - 2);
		x2 = (x * x + (64'd1 << 29)) >> 30;
		term = x;
		sum = x;
		for (int n = 1; n <= 8; n++) begin
			term = ((term * x2 + (64'd1 << 29)) >> 30) / TAYLOR_DIV[n-1];
			if ((n % 2) == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return COEF_BITS'(v);
	endfunction

	// Full-cycle table entry k, built from the first quadrant by symmetry.
	function automatic logic signed [COEF_BITS-1:0] sine_entry(input int unsigned k,
		input int unsigned ab);
		int unsigned quart;
		int unsigned q;
		int unsigned r;
		int unsigned rr;
		logic signed [COEF_BITS-1:0] e;
		quart = 32'd1 << (ab - 2);
		q = k >> (ab - 2);
		r = k & (quart - 1);
		rr = ((q & 1) != 0) ? (quart - r) : r;
		e = quarter_sine(rr, ab);
		return ((q & 2) != 0) ? -e : e;
	endfunction

endpackage

>>> sv/nco_real_to_complex_mixer.sv
// Real-to-complex NCO mixer. Every input sample is multiplied by cos and sin of
// a running phase read from a synchronous full-cycle sine ROM (two read ports,
// sine and cosine). The block takes one sample per clock while the pipeline is not
// stalled; the phase accumulator advances by an add in the accept stage. A result
// passes three register stages (ROM read, multiply, round/saturate into the output
// register) before it shows on m_axis_tvalid. Each stage holds only while the stage
// behind it is full and stalled, so input is taken as long as any stage is free.
// A sample with tuser (restart) set uses start_phase; next_phase in tdata is the
// phase after it.
// Depends on ncomix_pkg, ncomix_lane and nco_real_to_complex_mixer_macros.svh.
`include "nco_real_to_complex_mixer_macros.svh"

module nco_real_to_complex_mixer #(
	parameter int SAMPLE_BITS     = ncomix_pkg::DEF_SAMPLE_BITS,
	parameter int PHASE_BITS      = ncomix_pkg::DEF_PHASE_BITS,
	parameter int TABLE_ADDR_BITS = ncomix_pkg::DEF_TABLE_ADDR_BITS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// tdata: sample
	input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
	// tuser: restart
	input  logic                                   s_axis_tuser,
	input  logic                                   s_axis_tlast,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// tdata: real_part, imag_part, next_phase
	output logic [((2 * SAMPLE_BITS + PHASE_BITS + 7) / 8) * 8-1:0] m_axis_tdata,
	output logic                                   m_axis_tlast,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	input  logic                                   cfg_we,
	input  logic [ncomix_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
	input  logic [ncomix_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
	import ncomix_pkg::*;

	localparam int TBL_SIZE = 1 << TABLE_ADDR_BITS;
	localparam int OUT_DATA_BITS = ((2 * SAMPLE_BITS + PHASE_BITS + 7) / 8) * 8;
	localparam logic [TABLE_ADDR_BITS-1:0] QUART_OFS = TABLE_ADDR_BITS'(TBL_SIZE / 4);

	typedef logic signed [COEF_BITS-1:0] rom_t [TBL_SIZE];

	function automatic rom_t build_rom();
		rom_t t;
		for (int unsigned k = 0; k < TBL_SIZE; k++) begin
			t[k] = sine_entry(k, TABLE_ADDR_BITS);
		end
		return t;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	logic [PHASE_BITS-1:0] phase_step_q;
	logic [PHASE_BITS-1:0] start_phase_q;
	logic [PHASE_BITS-1:0] phase_acc_q;

	logic [PHASE_BITS-1:0]      ph;
	logic [PHASE_BITS-1:0]      nxt;
	logic [TABLE_ADDR_BITS-1:0] sin_addr;
	logic [TABLE_ADDR_BITS-1:0] cos_addr;
	logic                       s_fire;

	logic                          valid_s1;
	logic                          valid_s2;
	logic                          out_valid_q;
	logic signed [COEF_BITS-1:0]   sin_s1;
	logic signed [COEF_BITS-1:0]   cos_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic [PHASE_BITS-1:0]         nxt_s1;
	logic                          last_s1;
	logic [PHASE_BITS-1:0]         nxt_s2;
	logic                          last_s2;
	logic [PHASE_BITS-1:0]         next_phase_q;
	logic                          last_q;
	logic signed [SAMPLE_BITS-1:0] real_q;
	logic signed [SAMPLE_BITS-1:0] imag_q;

	logic     s1_en;
	pipe_en_t en;

	// A stage loads when it is empty or the stage behind it loads.
	always_comb begin
		en.out = !out_valid_q || m_axis_tready;
		en.s2 = !valid_s2 || en.out;
		s1_en = !valid_s1 || en.s2;
	end

	assign s_axis_tready = s1_en;
	assign s_fire = s_axis_tvalid && s1_en;

	always_comb begin
		ph = s_axis_tuser ? start_phase_q : phase_acc_q;
		nxt = ph + phase_step_q;
		sin_addr = ph[PHASE_BITS-1 -: TABLE_ADDR_BITS];
		cos_addr = sin_addr + QUART_OFS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= '0;
			start_phase_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				CFG_PHASE_STEP:  phase_step_q <= PHASE_BITS'(cfg_wdata);
				CFG_START_PHASE: start_phase_q <= PHASE_BITS'(cfg_wdata);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q <= '0;
		end else if (s_fire) begin
			phase_acc_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_en) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (en.s2) begin
				valid_s2 <= valid_s1;
			end
			if (en.out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	// Synchronous ROM read, two ports, registered with the rest of stage 1.
	always_ff @(posedge clk) begin
		if (s1_en) begin
			sin_s1 <= SINE_ROM[sin_addr];
			cos_s1 <= SINE_ROM[cos_addr];
			sample_s1 <= s_axis_tdata[SAMPLE_BITS-1:0];
			nxt_s1 <= nxt;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			nxt_s2 <= nxt_s1;
			last_s2 <= last_s1;
		end
		if (en.out) begin
			next_phase_q <= nxt_s2;
			last_q <= last_s2;
		end
	end

	ncomix_lane #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_lane_re (
		.clk      (clk),
		.en       (en),
		.sample_s1(sample_s1),
		.coef_s1  (cos_s1),
		.result_q (real_q)
	);

	ncomix_lane #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_lane_im (
		.clk      (clk),
		.en       (en),
		.sample_s1(sample_s1),
		.coef_s1  (sin_s1),
		.result_q (imag_q)
	);

	assign m_axis_tdata = OUT_DATA_BITS'({next_phase_q, imag_q, real_q});
	assign m_axis_tlast = last_q;
	assign m_axis_tvalid = out_valid_q;

	`NCOMIX_ASSERT_NEXT(a_acc_only_on_transfer, clk, arst_n, !s_fire, $stable(phase_acc_q))
	`NCOMIX_ASSERT_NEXT(a_transfer_fills_s1, clk, arst_n, s_fire, valid_s1)
	`NCOMIX_ASSERT_NEXT(a_out_from_s2, clk, arst_n, !valid_s2 && !out_valid_q, !out_valid_q)
	`NCOMIX_ASSERT_NOW(a_full_stall_blocks, clk, arst_n,
		valid_s1 && valid_s2 && out_valid_q && !m_axis_tready, !s_axis_tready)

endmodule

>>> sv/ncomix_lane.sv
// One mixing lane of the NCO mixer: registered product of sample and table
// value, then round half away from zero and saturate. Depends on ncomix_pkg.
module ncomix_lane #(
	parameter int SAMPLE_BITS = ncomix_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                 clk,
	input  ncomix_pkg::pipe_en_t                 en,
	input  logic signed [SAMPLE_BITS-1:0]        sample_s1,
	input  logic signed [ncomix_pkg::COEF_BITS-1:0] coef_s1,
	output logic signed [SAMPLE_BITS-1:0]        result_q
);
	import ncomix_pkg::*;

	localparam int PW = SAMPLE_BITS + COEF_BITS;
	localparam int SW = PW + 1 - COEF_FRAC;
	localparam logic signed [PW:0] RND_POS = (PW + 1)'(1) << (COEF_FRAC - 1);
	localparam logic signed [PW:0] RND_NEG = RND_POS - (PW + 1)'(1);
	localparam logic signed [SW-1:0] SAT_MAX = SW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] SAT_MIN = -SAT_MAX - SW'(1);

	logic signed [PW-1:0] prod_s2;
	logic signed [PW:0]   rnd;
	logic signed [SW-1:0] shifted;
	logic signed [SAMPLE_BITS-1:0] sat;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod_s2 <= sample_s1 * coef_s1;
		end
	end

	// A negative product gets one less of bias, so that ties round away from zero.
	always_comb begin
		rnd = {prod_s2[PW-1], prod_s2} + (prod_s2[PW-1] ? RND_NEG : RND_POS);
		shifted = rnd[PW:COEF_FRAC];
		if (shifted > SAT_MAX) begin
			sat = SAT_MAX[SAMPLE_BITS-1:0];
		end else if (shifted < SAT_MIN) begin
			sat = SAT_MIN[SAMPLE_BITS-1:0];
		end else begin
			sat = shifted[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en.out) begin
			result_q <= sat;
		end
	end

endmodule

>>> bench/nco_real_to_complex_mixer_tb.sv
// Self-checking bench for nco_real_to_complex_mixer: a directed table, then random vectors.
// Results are checked against a local predictor with its own sine table.
// Depends on ncomix_pkg and the mixer RTL only.
module nco_real_to_complex_mixer_tb;
	import ncomix_pkg::*;

	localparam int PIPE_LATENCY = 4;
	localparam int DRAIN_CYCLES = 12;
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 1700;
	localparam int LUT_SIZE = 1024;
	localparam int LUT_QUART = LUT_SIZE / 4;
	localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

	typedef struct packed {
		logic signed [15:0] re;
		logic signed [15:0] im;
		logic [31:0]        phase;
		logic               last;
	} mixed_sample_t;

	typedef struct packed {
		logic          valid;
		mixed_sample_t value;
	} pinned_t;

	typedef enum logic {DO_WRITE, DO_SAMPLE} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		cfg_reg_t           reg_idx;
		logic [31:0]        word;
		logic signed [15:0] smp;
		logic               restart;
		logic               last;
		logic               pinned;
		logic signed [15:0] re;
		logic signed [15:0] im;
		logic [31:0]        phase;
	} stim_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic [15:0]              s_axis_tdata;
	logic                     s_axis_tuser;
	logic                     s_axis_tlast;
	logic                     s_axis_tvalid;
	logic                     s_axis_tready;
	logic [63:0]              m_axis_tdata;
	logic                     m_axis_tlast;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	logic                     cfg_we;
	logic [CFG_ADDR_BITS-1:0] cfg_addr;
	logic [CFG_DATA_BITS-1:0] cfg_wdata;

	logic signed [15:0] sine_lut [LUT_SIZE];
	logic [31:0]        phase_acc;
	logic [31:0]        phase_step_q;
	logic [31:0]        start_phase_q;
	mixed_sample_t      expected_mix_q [$];
	pinned_t            pinned_q [$];
	int                 fail_count = 0;
	int                 samples_sent = 0;
	int                 stuck_cycles = 0;
	int unsigned        sink_hold = 0;
	int unsigned        sink_run = 0;

	// Pinned rows hold results worked out by hand; the other rows use the predictor.
	stim_row_t directed_tbl [25] = '{
		'{DO_SAMPLE, CFG_PHASE_STEP, 32'h0, 0, 0, 0, 1, 0, 0, 32'h0},
		'{DO_SAMPLE, CFG_PHASE_STEP, 32'h0, 32767, 0, 0, 1, 32766, 0, 32'h0},
		'{DO_SAMPLE, CFG_PHASE_STEP, 32'h0, -32768, 1, 0, 1, -32767, 0, 32'h0},
		'{DO_SAMPLE, CFG_PHASE_STEP, 32'h0, -1, 0, 1, 1, -1, 0, 32'h0},
		'{DO_SAMPLE, CFG_PHASE_STEP, 32'h0, 1, 1, 1, 1, 1, 0, 32'h0},
		'{DO_WRITE, CFG_PHASE_STEP, 32'h4000_0000, 0, 0, 0, 0, 0, 0, 32'h0},
		'{DO_WRITE, CFG_START_PHASE, 32'h0, 0, 0, 0, 0, 0, 0, 32'h0},
		'{DO_SAMPLE, CFG_PHASE_STEP, 32'h0, 32767, 1, 0, 1, 32766, 0, 32'h4000_0000},
		'{DO_SAMPLE, CFG_PHASE_STEP, 32'h0, 32767, 0, 0, 1, 0, 32766, 32'h8000_0000},
		'{DO_SAMPLE, CFG_PHASE_STEP, 32'h0, -32768, 0, 1, 1, 32767, 0, 32'hC000_0000},
		'{DO_SAMPLE, CFG_PHASE_STEP, 32'h0, 100, 0, 0, 1, 0, -100, 32'h0},
		'{DO_SAMPLE, CFG_PHASE_STEP, 32'h0, 12345, 0, 0, 0, 0, 0, 32'h0},
		'{DO_SAMPLE, CFG_PHASE_STEP, 32'h0, -12345, 1, 0, 0, 0, 0, 32'h0},
		'{DO_WRITE, CFG_PHASE_STEP, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 32'h0},
		'{DO_WRITE, CFG_START_PHASE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 32'h0},
		'{DO_SAMPLE, CFG_PHASE_STEP, 32'h0, 32767, 1, 1, 0, 0, 0, 32'h0},
		'{DO_SAMPLE, CFG_PHASE_STEP, 32'h0, -32768, 0, 0, 0, 0, 0, 32'h0},
		'{DO_SAMPLE, CFG_PHASE_STEP, 32'h0, 21845, 0, 0, 0, 0, 0, 32'h0},
		'{DO_SAMPLE, CFG_PHASE_STEP, 32'h0, -21846, 0, 1, 0, 0, 0, 32'h0},
		'{DO_WRITE, CFG_PHASE_STEP, 32'h0040_0000, 0, 0, 0, 0, 0, 0, 32'h0},
		'{DO_WRITE, CFG_START_PHASE, 32'h1234_5678, 0, 0, 0, 0, 0, 0, 32'h0},
		'{DO_SAMPLE, CFG_PHASE_STEP, 32'h0, 30000, 1, 0, 0, 0, 0, 32'h0},
		'{DO_SAMPLE, CFG_PHASE_STEP, 32'h0, -30000, 0, 0, 0, 0, 0, 32'h0},
		'{DO_SAMPLE, CFG_PHASE_STEP, 32'h0, -2, 1, 0, 0, 0, 0, 32'h0},
		'{DO_SAMPLE, CFG_PHASE_STEP, 32'h0, 2, 0, 1, 0, 0, 0, 32'h0}
	};

	nco_real_to_complex_mixer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata)
	);

	always #5 clk = ~clk;

	// First-quadrant amplitude: Q30 Taylor series of sin, scaled to 32767 and clamped.
	function automatic int unsigned quarter_amp(input int unsigned r);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned total;
		longint unsigned v;
		x = (QUARTER_TURN_Q30 * r + (LUT_QUART / 2)) / LUT_QUART;
		x2 = (x * x + (64'd1 << 29)) >> 30;
		term = x;
		total = x;
		for (int n = 1; n <= 8; n++) begin
			term = ((term * x2 + (64'd1 << 29)) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				total = total - term;
			end else begin
				total = total + term;
			end
		end
		v = (total * 64'd32767 + (64'd1 << 29)) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return int'(v);
	endfunction

	// Full-precision product, shifted by 15 with ties away from zero, then saturated.
	function automatic logic signed [15:0] round_q15(input logic signed [15:0] smp,
		input logic signed [15:0] coef);
		longint p;
		longint mag;
		longint r;
		p = longint'(smp) * longint'(coef);
		mag = (p < 0) ? -p : p;
		mag = (mag + 16384) >> 15;
		r = (p < 0) ? -mag : mag;
		if (r > 32767) begin
			r = 32767;
		end
		if (r < -32768) begin
			r = -32768;
		end
		return r[15:0];
	endfunction

	function automatic mixed_sample_t mix_at_phase(input logic signed [15:0] smp,
		input logic [31:0] ph, input logic lst);
		mixed_sample_t m;
		logic [9:0]    sin_idx;
		logic [9:0]    cos_idx;
		sin_idx = ph[31:22];
		cos_idx = sin_idx + 10'(LUT_QUART);
		m.re = round_q15(smp, sine_lut[cos_idx]);
		m.im = round_q15(smp, sine_lut[sin_idx]);
		m.phase = ph + phase_step_q;
		m.last = lst;
		return m;
	endfunction

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] pick_phase_word();
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(1, 32'h0040_0000);
			3: return 32'h8000_0000;
			4: return 32'h0040_0000 * $urandom_range(1, 8);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return 16'($urandom_range(0, 4) - 2);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		for (int k = 0; k < LUT_SIZE; k++) begin
			if ((k / LUT_QUART) % 2 == 1) begin
				sine_lut[k] = 16'(quarter_amp(LUT_QUART - k % LUT_QUART));
			end else begin
				sine_lut[k] = 16'(quarter_amp(k % LUT_QUART));
			end
			if ((k / LUT_QUART) >= 2) begin
				sine_lut[k] = -sine_lut[k];
			end
		end
	end

	// Sink: ready drops for random stretches, with runs of steady acceptance between.
	always @(posedge clk) begin
		if (sink_hold > 0) begin
			sink_hold--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if (sink_run > 0) begin
				sink_run--;
			end else begin
				sink_run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
					: $urandom_range(0, 40);
				sink_hold = idle_len();
			end
		end
	end

	// Predicts each accepted sample and checks each result transfer against the oldest one.
	always @(posedge clk) begin : mixer_scoreboard
		pinned_t       pin;
		mixed_sample_t want;
		mixed_sample_t got;
		logic [31:0]   ph;
		if (!arst_n) begin
			phase_acc = '0;
			phase_step_q = '0;
			start_phase_q = '0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.re = m_axis_tdata[15:0];
				got.im = m_axis_tdata[31:16];
				got.phase = m_axis_tdata[63:32];
				got.last = m_axis_tlast;
				if (expected_mix_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("unexpected result: re=%0d im=%0d phase=%h last=%b",
							got.re, got.im, got.phase, got.last);
					end
				end else begin
					want = expected_mix_q.pop_front();
					if (got != want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("mismatch at %0t: re %0d/%0d im %0d/%0d phase %h/%h last %b/%b",
								$realtime, want.re, got.re, want.im, got.im,
								want.phase, got.phase, want.last, got.last);
						end
					end
				end
			end
			if (cfg_we) begin
				case (cfg_addr)
					CFG_PHASE_STEP:  phase_step_q = cfg_wdata;
					CFG_START_PHASE: start_phase_q = cfg_wdata;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				ph = s_axis_tuser ? start_phase_q : phase_acc;
				want = mix_at_phase(s_axis_tdata, ph, s_axis_tlast);
				phase_acc = want.phase;
				if (pinned_q.size() != 0) begin
					pin = pinned_q.pop_front();
					if (pin.valid) begin
						want = pin.value;
					end
				end
				expected_mix_q.push_back(want);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	task automatic send_sample(input logic signed [15:0] smp, input logic rs, input logic lst,
		input bit quiet, input pinned_t pin);
		int unsigned gap;
		gap = quiet ? 0 : idle_len();
		pinned_q.push_back(pin);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata <= smp;
		s_axis_tuser <= rs;
		s_axis_tlast <= lst;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		samples_sent++;
	endtask

	// Registers change only with the pipeline empty.
	task automatic write_reg(input cfg_reg_t reg_idx, input logic [31:0] val);
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (expected_mix_q.size() != 0);
		repeat (PIPE_LATENCY) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= reg_idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		pinned_t     pin;
		int unsigned phase_end;
		int unsigned vec_len;
		bit          quiet;
		arst_n = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		s_axis_tlast = 1'b0;
		s_axis_tvalid = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_tbl[i]) begin
			if (directed_tbl[i].kind == DO_WRITE) begin
				write_reg(directed_tbl[i].reg_idx, directed_tbl[i].word);
			end else begin
				pin.valid = directed_tbl[i].pinned;
				pin.value.re = directed_tbl[i].re;
				pin.value.im = directed_tbl[i].im;
				pin.value.phase = directed_tbl[i].phase;
				pin.value.last = directed_tbl[i].last;
				send_sample(directed_tbl[i].smp, directed_tbl[i].restart,
					directed_tbl[i].last, 1'b0, pin);
			end
		end

		// Random phases: new register values, then mostly well-formed vectors.
		while (samples_sent < $size(directed_tbl) + RANDOM_ITEMS) begin
			write_reg(CFG_PHASE_STEP, pick_phase_word());
			if ($urandom_range(0, 1) == 1) begin
				write_reg(CFG_START_PHASE, pick_phase_word());
			end
			phase_end = samples_sent + $urandom_range(60, 220);
			while (samples_sent < phase_end) begin
				quiet = ($urandom_range(0, 4) == 0);
				if ($urandom_range(0, 9) < 8) begin
					vec_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
						: $urandom_range(1, 16);
					for (int i = 0; i < vec_len; i++) begin
						send_sample(pick_sample(), i == 0, i == vec_len - 1, quiet, '0);
					end
				end else begin
					vec_len = $urandom_range(1, 10);
					for (int i = 0; i < vec_len; i++) begin
						send_sample(pick_sample(), $urandom_range(0, 3) == 0,
							$urandom_range(0, 3) == 0, quiet, '0);
					end
				end
			end
		end

		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (expected_mix_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_mix_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
